// ===== hdl/drpi_pkg.sv =====
package drpi_pkg;

	typedef struct packed {
		logic signed [23:0] forward_speed;
		logic signed [23:0] yaw_rate;
		logic        [19:0] elapsed_time;
	} tick_t;

	typedef struct packed {
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
		logic        [31:0] heading_angle;
		logic signed [23:0] world_velocity_x;
		logic signed [23:0] world_velocity_y;
		logic signed [23:0] yaw_rate_echo;
		logic signed [15:0] quaternion_z;
		logic signed [15:0] quaternion_w;
	} pose_t;

	// multiplier operand sources
	typedef enum logic [3:0] {
		SRC_NONE, SRC_YAW, SRC_SPD, SRC_DT, SRC_ZA, SRC_ZB, SRC_Z2A, SRC_Z2B,
		SRC_TA, SRC_TB, SRC_C4, SRC_DLO, SRC_DHI, SRC_COS, SRC_SIN
	} src_t;

	// writeback of the product issued one step earlier
	typedef enum logic [3:0] {
		WB_NONE, WB_HEAD, WB_DIST, WB_Z2A, WB_Z2B, WB_TA, WB_TB, WB_FINA, WB_FINB,
		WB_VX, WB_VY, WB_ACCX_LO, WB_ACCX_HI, WB_ACCY_LO, WB_ACCY_HI
	} wb_t;

	// operations that do not use the product
	typedef enum logic [2:0] {
		AUX_NONE, AUX_LOAD_HEAD, AUX_LOAD_HALF, AUX_POSX, AUX_POSY, AUX_NEXT_PASS,
		AUX_OUT
	} aux_t;

	typedef enum logic [1:0] {
		JMP_NONE, JMP_ALWAYS, JMP_IF_PASS
	} jmp_t;

	typedef struct packed {
		src_t       opa;
		src_t       opb;
		wb_t        wb;
		logic [2:0] wcoef;
		aux_t       aux;
		jmp_t       jmp;
		logic [4:0] target;
	} ucode_t;

	localparam logic [4:0] STEP_POLY = 5'd3;
	localparam logic [4:0] STEP_TAIL = 5'd22;

	// sin(pi*z/2) odd polynomial, Q30
	localparam logic [30:0] POLY_COEF [5] = '{
		31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026994, 31'd172273
	};

	localparam logic [2:0] COEF_C4 = 3'd4;

	// quarter-turn fraction fed to the polynomial, mirrored in odd quadrants
	function automatic logic [30:0] quad_z(input logic [31:0] a);
		logic [30:0] f;
		f = {1'b0, a[29:0]};
		if (a[30])
			quad_z = 31'h4000_0000 - f;
		else
			quad_z = f;
	endfunction

	function automatic ucode_t uc(input src_t a, input src_t b, input wb_t w,
			input logic [2:0] k, input aux_t x, input jmp_t j, input logic [4:0] t);
		uc = '{opa: a, opb: b, wb: w, wcoef: k, aux: x, jmp: j, target: t};
	endfunction

	// control store: two passes of the shared sine/cosine kernel,
	// lane a and lane b interleaved so the multiplier issues on every kernel step
	function automatic ucode_t ucode_rom(input logic [4:0] step);
		ucode_t w;
		case (step)
			5'd0: w = uc(SRC_YAW, SRC_DT, WB_NONE, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd1: w = uc(SRC_SPD, SRC_DT, WB_HEAD, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd2: w = uc(SRC_NONE, SRC_NONE, WB_DIST, 3'd0, AUX_LOAD_HEAD, JMP_NONE, 5'd0);
			5'd3: w = uc(SRC_ZA, SRC_ZA, WB_NONE, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd4: w = uc(SRC_ZB, SRC_ZB, WB_Z2A, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd5: w = uc(SRC_C4, SRC_Z2A, WB_Z2B, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd6: w = uc(SRC_C4, SRC_Z2B, WB_TA, 3'd3, AUX_NONE, JMP_NONE, 5'd0);
			5'd7: w = uc(SRC_TA, SRC_Z2A, WB_TB, 3'd3, AUX_NONE, JMP_NONE, 5'd0);
			5'd8: w = uc(SRC_TB, SRC_Z2B, WB_TA, 3'd2, AUX_NONE, JMP_NONE, 5'd0);
			5'd9: w = uc(SRC_TA, SRC_Z2A, WB_TB, 3'd2, AUX_NONE, JMP_NONE, 5'd0);
			5'd10: w = uc(SRC_TB, SRC_Z2B, WB_TA, 3'd1, AUX_NONE, JMP_NONE, 5'd0);
			5'd11: w = uc(SRC_TA, SRC_Z2A, WB_TB, 3'd1, AUX_NONE, JMP_NONE, 5'd0);
			5'd12: w = uc(SRC_TB, SRC_Z2B, WB_TA, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd13: w = uc(SRC_TA, SRC_ZA, WB_TB, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd14: w = uc(SRC_TB, SRC_ZB, WB_FINA, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd15: w = uc(SRC_SPD, SRC_COS, WB_FINB, 3'd0, AUX_LOAD_HALF, JMP_IF_PASS,
				STEP_TAIL);
			5'd16: w = uc(SRC_SPD, SRC_SIN, WB_VX, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd17: w = uc(SRC_DLO, SRC_COS, WB_VY, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd18: w = uc(SRC_DHI, SRC_COS, WB_ACCX_LO, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd19: w = uc(SRC_DLO, SRC_SIN, WB_ACCX_HI, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
			5'd20: w = uc(SRC_DHI, SRC_SIN, WB_ACCY_LO, 3'd0, AUX_POSX, JMP_NONE, 5'd0);
			5'd21: w = uc(SRC_NONE, SRC_NONE, WB_ACCY_HI, 3'd0, AUX_NEXT_PASS, JMP_ALWAYS,
				STEP_POLY);
			5'd22: w = uc(SRC_NONE, SRC_NONE, WB_NONE, 3'd0, AUX_POSY, JMP_NONE, 5'd0);
			5'd23: w = uc(SRC_NONE, SRC_NONE, WB_NONE, 3'd0, AUX_OUT, JMP_NONE, 5'd0);
			default: w = uc(SRC_NONE, SRC_NONE, WB_NONE, 3'd0, AUX_NONE, JMP_NONE, 5'd0);
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/dead_reckoning_pose_integrator_core.sv =====
// channel   dir  handshake                 payload
// tick      in   tick_valid / tick_ready   tick_t: forward_speed, yaw_rate, elapsed_time
// pose      out  pose_valid / pose_ready   pose_t: position, heading, velocity, quaternion
//
// each tick runs its microcode steps after the accept cycle, paced by the
// single shared 33x33 multiplier that issues one product per step
// the sine kernel runs twice (heading, then half heading) on two interleaved lanes
// arst_n clears the heading and position, the sequencer and the output valid
// a finished pose waits in the output register while the next tick is computed;
// the sequencer holds on its last step only while that register is still full
module dead_reckoning_pose_integrator_core
	import drpi_pkg::*;
#(
	parameter int POSITION_BITS      = 48,
	parameter int TRIG_FRACTION_BITS = 15
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tick_valid,
	output logic  tick_ready,
	input  tick_t tick,
	output logic  pose_valid,
	input  logic  pose_ready,
	output pose_t pose
);

	localparam int PB = POSITION_BITS;
	localparam int T  = TRIG_FRACTION_BITS;
	localparam int TW = T + 1;                         // signed trig value width
	localparam logic [31:0] RND_HALF = 32'(1) << (29 - T);
	localparam int RND_SH = 30 - T;
	localparam logic [31:0] TRIG_MAX32 = (32'(1) << T) - 32'd1;
	localparam int POS_SH = 20 + T;
	localparam int QR = (T >= 15) ? (T - 15) : 0;      // quaternion rescale to Q1.15
	localparam int QL = (T < 15) ? (15 - T) : 0;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic pass_q;
	ucode_t cw;
	logic step_go;

	// captured request
	logic signed [23:0] spd_q;
	logic signed [23:0] yaw_q;
	logic        [19:0] dt_q;

	// pose state
	logic [31:0]   head_q;
	logic [PB-1:0] px_q;
	logic [PB-1:0] py_q;

	// datapath
	logic [43:0] dist_q;
	logic [30:0] za_q, zb_q, z2a_q, z2b_q, ta_q, tb_q;
	logic        na_q, nb_q;
	logic signed [TW-1:0] cos_q, sin_q, qw_q, qz_q;
	logic [23:0] vx_q, vy_q;
	logic [63:0] accx_q, accy_q;
	logic signed [32:0] opa, opb;
	logic signed [65:0] mul_full;
	logic [63:0] prod_s1;

	logic [31:0] ld_base, ld_alt;
	logic [63:0] accx_sh, accy_sh;
	logic [63:0] px_w, py_w;
	logic signed [39:0] qz_ext, qw_ext;
	logic signed [TW-1:0] fin_a, fin_b;

	pose_t pose_q;
	logic  pose_valid_q;

	// rounds the Q30 polynomial output to Q1.T, saturates, applies quadrant sign
	function automatic logic signed [TW-1:0] finish(input logic [63:0] p, input logic neg);
		logic [31:0] rnd;
		logic [TW-1:0] mag;
		rnd = ({1'b0, p[60:30]} + RND_HALF) >> RND_SH;
		if (rnd > TRIG_MAX32)
			mag = TW'(TRIG_MAX32);
		else
			mag = rnd[TW-1:0];
		if (neg)
			finish = -$signed(mag);
		else
			finish = $signed(mag);
	endfunction

	assign cw = ucode_rom(step_q);
	assign step_go = (cw.aux != AUX_OUT) || !pose_valid_q || pose_ready;
	assign tick_ready = (state_q == ST_IDLE);
	assign pose_valid = pose_valid_q;
	assign pose = pose_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			pass_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
						pass_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (step_go) begin
						if (cw.aux == AUX_OUT)
							state_q <= ST_IDLE;
						if (cw.aux == AUX_NEXT_PASS)
							pass_q <= 1'b1;
						if (cw.jmp == JMP_ALWAYS || (cw.jmp == JMP_IF_PASS && pass_q))
							step_q <= cw.target;
						else
							step_q <= step_q + 5'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operand select
	always_comb begin
		case (cw.opa)
			SRC_YAW: opa = 33'(yaw_q);
			SRC_SPD: opa = 33'(spd_q);
			SRC_DT:  opa = $signed(33'(dt_q));
			SRC_ZA:  opa = $signed(33'(za_q));
			SRC_ZB:  opa = $signed(33'(zb_q));
			SRC_Z2A: opa = $signed(33'(z2a_q));
			SRC_Z2B: opa = $signed(33'(z2b_q));
			SRC_TA:  opa = $signed(33'(ta_q));
			SRC_TB:  opa = $signed(33'(tb_q));
			SRC_C4:  opa = $signed(33'(POLY_COEF[COEF_C4]));
			SRC_DLO: opa = $signed(33'(dist_q[21:0]));
			SRC_DHI: opa = 33'($signed(dist_q[43:22]));
			SRC_COS: opa = 33'(cos_q);
			SRC_SIN: opa = 33'(sin_q);
			default: opa = '0;
		endcase
		case (cw.opb)
			SRC_YAW: opb = 33'(yaw_q);
			SRC_SPD: opb = 33'(spd_q);
			SRC_DT:  opb = $signed(33'(dt_q));
			SRC_ZA:  opb = $signed(33'(za_q));
			SRC_ZB:  opb = $signed(33'(zb_q));
			SRC_Z2A: opb = $signed(33'(z2a_q));
			SRC_Z2B: opb = $signed(33'(z2b_q));
			SRC_TA:  opb = $signed(33'(ta_q));
			SRC_TB:  opb = $signed(33'(tb_q));
			SRC_C4:  opb = $signed(33'(POLY_COEF[COEF_C4]));
			SRC_DLO: opb = $signed(33'(dist_q[21:0]));
			SRC_DHI: opb = 33'($signed(dist_q[43:22]));
			SRC_COS: opb = 33'(cos_q);
			SRC_SIN: opb = 33'(sin_q);
			default: opb = '0;
		endcase
	end

	assign mul_full = opa * opb;

	// lane angles: lane a takes the cosine (angle plus a quarter turn), lane b the sine
	assign ld_base = (cw.aux == AUX_LOAD_HALF) ? {1'b0, head_q[31:1]} : head_q;
	assign ld_alt  = ld_base + 32'h4000_0000;

	assign accx_sh = 64'($signed(accx_q) >>> POS_SH);
	assign accy_sh = 64'($signed(accy_q) >>> POS_SH);
	assign fin_a   = finish(prod_s1, na_q);
	assign fin_b   = finish(prod_s1, nb_q);

	// result formatting
	assign px_w   = 64'(px_q);
	assign py_w   = 64'(py_q);
	assign qz_ext = (40'(qz_q) <<< QL) >>> QR;
	assign qw_ext = (40'(qw_q) <<< QL) >>> QR;

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			spd_q <= tick.forward_speed;
			yaw_q <= tick.yaw_rate;
			dt_q  <= tick.elapsed_time;
		end

		prod_s1 <= mul_full[63:0];

		if (state_q == ST_RUN) begin
			case (cw.wb)
				WB_DIST:    dist_q <= prod_s1[43:0];
				WB_Z2A:     z2a_q <= prod_s1[60:30];
				WB_Z2B:     z2b_q <= prod_s1[60:30];
				WB_TA:      ta_q <= POLY_COEF[cw.wcoef] - prod_s1[60:30];
				WB_TB:      tb_q <= POLY_COEF[cw.wcoef] - prod_s1[60:30];
				WB_FINA: begin
					if (pass_q)
						qw_q <= fin_a;
					else
						cos_q <= fin_a;
				end
				WB_FINB: begin
					if (pass_q)
						qz_q <= fin_b;
					else
						sin_q <= fin_b;
				end
				WB_VX:      vx_q <= prod_s1[T+23:T];
				WB_VY:      vy_q <= prod_s1[T+23:T];
				WB_ACCX_LO: accx_q <= prod_s1;
				WB_ACCX_HI: accx_q <= accx_q + (prod_s1 << 22);
				WB_ACCY_LO: accy_q <= prod_s1;
				WB_ACCY_HI: accy_q <= accy_q + (prod_s1 << 22);
				default: ;
			endcase

			if (step_go) begin
				case (cw.aux)
					AUX_LOAD_HEAD, AUX_LOAD_HALF: begin
						za_q <= quad_z(ld_alt);
						na_q <= ld_alt[31];
						zb_q <= quad_z(ld_base);
						nb_q <= ld_base[31];
					end
					AUX_OUT: begin
						pose_q.position_x       <= px_w[47:0];
						pose_q.position_y       <= py_w[47:0];
						pose_q.heading_angle    <= head_q;
						pose_q.world_velocity_x <= vx_q;
						pose_q.world_velocity_y <= vy_q;
						pose_q.yaw_rate_echo    <= yaw_q;
						pose_q.quaternion_z     <= qz_ext[15:0];
						pose_q.quaternion_w     <= qw_ext[15:0];
					end
					default: ;
				endcase
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid_q <= 1'b0;
		end else if (state_q == ST_RUN && cw.aux == AUX_OUT && step_go) begin
			pose_valid_q <= 1'b1;
		end else if (pose_ready) begin
			pose_valid_q <= 1'b0;
		end
	end

	// heading and position, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			px_q   <= '0;
			py_q   <= '0;
		end else begin
			if (state_q == ST_RUN && cw.wb == WB_HEAD)
				head_q <= head_q + prod_s1[35:4];
			if (state_q == ST_RUN && step_go && cw.aux == AUX_POSX)
				px_q <= px_q + accx_sh[PB-1:0];
			if (state_q == ST_RUN && step_go && cw.aux == AUX_POSY)
				py_q <= py_q + accy_sh[PB-1:0];
		end
	end

endmodule

// ===== hdl/drpi_checker.sv =====
module drpi_checker
	import drpi_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  tick_valid,
	input logic  tick_ready,
	input tick_t tick,
	input logic  pose_valid,
	input logic  pose_ready,
	input pose_t pose
);

	logic [1:0] outstanding_q;
	logic tick_acc, pose_acc;

	assign tick_acc = tick_valid && tick_ready;
	assign pose_acc = pose_valid && pose_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (tick_acc && !pose_acc) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (pose_acc && !tick_acc) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> !tick_ready)
		else $error("tick taken while a request is still being computed");

	a_no_invented_pose: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid |-> outstanding_q != 2'd0)
		else $error("pose offered with no request outstanding");

	a_bounded_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q != 2'd3)
		else $error("more than two requests outstanding");

	a_pose_held: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_ready |=> pose_valid && $stable(pose))
		else $error("stalled pose dropped or changed");

endmodule

bind dead_reckoning_pose_integrator_core drpi_checker u_drpi_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import drpi_pkg::*;

	// fixed-point constants of the odometry math
	localparam longint unsigned SIN_C1 = 64'd1686629713;
	localparam longint unsigned SIN_C3 = 64'd693598668;
	localparam longint unsigned SIN_C5 = 64'd85569306;
	localparam longint unsigned SIN_C7 = 64'd5026994;
	localparam longint unsigned SIN_C9 = 64'd172273;
	localparam longint unsigned TRIG_FULL = 64'd32767;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam logic [23:0] VAL24_MAX = 24'h7F_FFFF;
	localparam logic [23:0] VAL24_MIN = 24'h80_0000;
	localparam logic [19:0] DT_MAX = 20'hF_FFFF;
	// 65536 * 262144 >> 4 is exactly a quarter turn of heading
	localparam logic [23:0] QUARTER_YAW = 24'd65536;
	localparam logic [19:0] QUARTER_DT = 20'd262144;
	// 1/20 s in 2^-20 s units, the nominal control-loop tick
	localparam int NOMINAL_DT = 52429;

	localparam int RANDOM_PER_PHASE = 410;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		tick_t stim;
		bit    known;
		pose_t golden;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  tick_valid;
	logic  tick_ready;
	tick_t tick;
	logic  pose_valid;
	logic  pose_ready;
	pose_t pose;

	// integrated pose as the block should hold it
	logic [31:0] dr_heading;
	logic [47:0] dr_x;
	logic [47:0] dr_y;

	pose_t expected_poses[$];
	row_t  directed_rows[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_request;
	int  mismatch_count;
	int  poses_checked;
	int  ticks_sent;
	int  quiet_cycles;
	bit [3:0] quadrants_seen;

	dead_reckoning_pose_integrator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.tick      (tick),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose      (pose)
	);

	always #2 clk = ~clk;

	// sin(pi*z/2) for a Q30 quarter-turn fraction, rounded to Q1.15 and clipped below one
	function automatic longint unsigned quarter_wave(input longint unsigned z);
		longint unsigned z2, acc, r;
		z2 = (z * z) >> 30;
		acc = SIN_C7 - ((SIN_C9 * z2) >> 30);
		acc = SIN_C5 - ((acc * z2) >> 30);
		acc = SIN_C3 - ((acc * z2) >> 30);
		acc = SIN_C1 - ((acc * z2) >> 30);
		acc = (acc * z) >> 30;
		r = (acc + (64'd1 << 14)) >> 15;
		if (r > TRIG_FULL)
			r = TRIG_FULL;
		return r;
	endfunction

	// full-turn sine of a binary angle: quadrant folds the fraction and the sign
	function automatic longint trig_sine(input logic [31:0] a);
		longint unsigned frac;
		longint mag;
		frac = {34'd0, a[29:0]};
		if (a[30])
			mag = quarter_wave((64'd1 << 30) - frac);
		else
			mag = quarter_wave(frac);
		return a[31] ? -mag : mag;
	endfunction

	function automatic longint trig_cosine(input logic [31:0] a);
		return trig_sine(a + QUARTER_TURN);
	endfunction

	// one odometry tick: turn first, then move along the new heading
	function automatic pose_t advance_pose(input tick_t t);
		longint spd, yaw, dt, travel, turn, cs, sn, step, vel, q;
		logic [31:0] half;
		pose_t p;
		spd = 64'(t.forward_speed);
		yaw = 64'(t.yaw_rate);
		dt = 64'(t.elapsed_time);
		travel = spd * dt;
		turn = (yaw * dt) >>> 4;
		dr_heading = dr_heading + turn[31:0];
		cs = trig_cosine(dr_heading);
		sn = trig_sine(dr_heading);
		step = (travel * cs) >>> 35;
		dr_x = dr_x + step[47:0];
		step = (travel * sn) >>> 35;
		dr_y = dr_y + step[47:0];
		p.position_x = dr_x;
		p.position_y = dr_y;
		p.heading_angle = dr_heading;
		vel = (spd * cs) >>> 15;
		p.world_velocity_x = vel[23:0];
		vel = (spd * sn) >>> 15;
		p.world_velocity_y = vel[23:0];
		p.yaw_rate_echo = t.yaw_rate;
		// half angle taken as heading >> 1, so the z term never goes negative
		half = dr_heading >> 1;
		q = trig_sine(half);
		p.quaternion_z = q[15:0];
		q = trig_cosine(half);
		p.quaternion_w = q[15:0];
		return p;
	endfunction

	// pose of a robot that has not moved yet, for rows read off by hand
	function automatic pose_t still_pose(input logic [23:0] vx, input logic [23:0] yaw,
			input logic [15:0] qw);
		pose_t p;
		p = '0;
		p.world_velocity_x = vx;
		p.yaw_rate_echo = yaw;
		p.quaternion_w = qw;
		return p;
	endfunction

	function automatic logic [23:0] pick_extreme24();
		case ($urandom_range(3))
			0: return VAL24_MAX;
			1: return VAL24_MIN;
			2: return 24'd0;
			default: return 24'hFF_FFFF;
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		case ($urandom_range(9))
			0, 1, 2: begin
				// full range of every field
				t.forward_speed = 24'($urandom);
				t.yaw_rate = 24'($urandom);
				t.elapsed_time = 20'($urandom);
			end
			3, 4: begin
				t.forward_speed = 24'($urandom_range(131071) - 65536);
				t.yaw_rate = 24'($urandom_range(131071) - 65536);
				t.elapsed_time = 20'($urandom_range(65535));
			end
			5: begin
				// stationary tick, velocities still reported
				t.forward_speed = 24'($urandom);
				t.yaw_rate = 24'($urandom);
				t.elapsed_time = '0;
			end
			6: begin
				t.forward_speed = pick_extreme24();
				t.yaw_rate = pick_extreme24();
				case ($urandom_range(2))
					0: t.elapsed_time = '0;
					1: t.elapsed_time = 20'd1;
					default: t.elapsed_time = DT_MAX;
				endcase
			end
			default: begin
				// typical driving at the control-loop rate
				t.forward_speed = 24'($urandom_range(262143) - 131072);
				t.yaw_rate = 24'($urandom_range(1048575) - 524288);
				t.elapsed_time = 20'($urandom_range(NOMINAL_DT + 4096, NOMINAL_DT - 4096));
			end
		endcase
		return t;
	endfunction

	task automatic add_row(input logic [23:0] speed, input logic [23:0] yaw,
			input logic [19:0] dt, input bit known, input pose_t golden);
		row_t r;
		r.stim.forward_speed = speed;
		r.stim.yaw_rate = yaw;
		r.stim.elapsed_time = dt;
		r.known = known;
		r.golden = golden;
		directed_rows.push_back(r);
	endtask

	// present one request, hold it until taken, then queue the pose it must produce
	task automatic offer_tick(input tick_t t, input bit known, input pose_t golden);
		pose_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		tick <= t;
		do
			@(posedge clk);
		while (!tick_ready);
		predicted = advance_pose(t);
		quadrants_seen[predicted.heading_angle[31:30]] = 1'b1;
		expected_poses.push_back(known ? golden : predicted);
		ticks_sent++;
	endtask

	// stop offering and wait for every queued pose
	task automatic drain();
		tick_valid <= 1'b0;
		while (expected_poses.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("pose %0d %s: expected %0h got %0h", poses_checked, field, want, got);
		end
	endtask

	task automatic check_pose(input pose_t got);
		pose_t want;
		if (expected_poses.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("pose %0d arrived with no request outstanding", poses_checked);
		end else begin
			want = expected_poses.pop_front();
			check_field("position_x", 64'(want.position_x), 64'(got.position_x));
			check_field("position_y", 64'(want.position_y), 64'(got.position_y));
			check_field("heading_angle", 64'(want.heading_angle), 64'(got.heading_angle));
			check_field("world_velocity_x", 64'(want.world_velocity_x),
				64'(got.world_velocity_x));
			check_field("world_velocity_y", 64'(want.world_velocity_y),
				64'(got.world_velocity_y));
			check_field("yaw_rate_echo", 64'(want.yaw_rate_echo), 64'(got.yaw_rate_echo));
			check_field("quaternion_z", 64'(want.quaternion_z), 64'(got.quaternion_z));
			check_field("quaternion_w", 64'(want.quaternion_w), 64'(got.quaternion_w));
		end
		poses_checked++;
	endtask

	// output side: check every accepted pose, then pick ready for the next edge
	initial begin
		int hold_left;
		hold_left = 0;
		pose_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pose_valid && pose_ready)
				check_pose(pose);
			if (hold_request) begin
				hold_left = LONG_HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				// long back-pressure so the output register fills and the input stalls
				hold_left--;
				pose_ready <= 1'b0;
			end else begin
				pose_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// no handshake on either side for too long means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && tick_ready) || (pose_valid && pose_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d poses still due",
				quiet_cycles, expected_poses.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int phase;
		int i;
		clk = 1'b0;
		arst_n <= 1'b0;
		tick_valid <= 1'b0;
		tick <= '0;
		dr_heading = '0;
		dr_x = '0;
		dr_y = '0;
		hold_request = 1'b0;
		mismatch_count = 0;
		poses_checked = 0;
		ticks_sent = 0;
		quadrants_seen = '0;
		send_idle_pct = 34;
		recv_idle_pct = 57;

		// requests whose pose is obvious straight out of reset
		add_row(24'd0, 24'd0, 20'd0, 1'b1, still_pose(24'd0, 24'd0, 16'sd32767));
		// full-scale cosine clips at 32767, so max speed loses 256 counts
		add_row(VAL24_MAX, 24'd0, 20'd0, 1'b1, still_pose(24'd8388351, 24'd0, 16'sd32767));
		add_row(VAL24_MIN, VAL24_MAX, 20'd0, 1'b1,
			still_pose(-24'sd8388352, VAL24_MAX, 16'sd32767));
		// four exact quarter turns walk the heading through every quadrant and wrap
		add_row(24'd100000, QUARTER_YAW, QUARTER_DT, 1'b0, '0);
		add_row(24'd100000, QUARTER_YAW, QUARTER_DT, 1'b0, '0);
		add_row(-24'sd70000, QUARTER_YAW, QUARTER_DT, 1'b0, '0);
		add_row(24'd100000, QUARTER_YAW, QUARTER_DT, 1'b0, '0);
		add_row(-24'sd5000, -24'sd65536, QUARTER_DT, 1'b0, '0);
		// field extremes together
		add_row(VAL24_MAX, VAL24_MAX, DT_MAX, 1'b0, '0);
		add_row(VAL24_MIN, VAL24_MIN, DT_MAX, 1'b0, '0);
		add_row(VAL24_MAX, 24'd0, DT_MAX, 1'b0, '0);
		add_row(VAL24_MIN, 24'd0, DT_MAX, 1'b0, '0);
		// turn below one lsb: positive rounds to nothing, negative floors to -1
		add_row(24'd1, 24'd1, 20'd1, 1'b0, '0);
		add_row(24'hFF_FFFF, 24'hFF_FFFF, 20'd1, 1'b0, '0);
		// alternating bit patterns on every field
		add_row(24'h55_5555, 24'hAA_AAAA, 20'h5_5555, 1'b0, '0);
		add_row(24'hAA_AAAA, 24'h55_5555, 20'hA_AAAA, 1'b0, '0);
		// maximum yaw over a long interval, whose turn wraps modulo a full turn
		add_row(24'd3000, VAL24_MAX, 20'd131072, 1'b0, '0);
		// zero time: pose holds, velocity still follows the heading
		add_row(24'd12345, 24'h00_7FFF, 20'd0, 1'b0, '0);
		add_row(VAL24_MIN, VAL24_MIN, 20'd0, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			offer_tick(directed_rows[k].stim, directed_rows[k].known, directed_rows[k].golden);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (i = 0; i < RANDOM_PER_PHASE; i++) begin
				// with no idling the sender keeps pushing through the long hold
				if (phase == 2 && i == 100)
					hold_request = 1'b1;
				offer_tick(random_tick(), 1'b0, '0);
			end
			drain();
		end

		// anything arriving now has no request behind it
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d odometry ticks driven (%0d directed), %0d poses checked, %0d mismatches",
			ticks_sent, directed_rows.size(), poses_checked, mismatch_count);
		$display("heading quadrants reached %b, with both-side idling, a %0d-cycle output stall",
			quadrants_seen, LONG_HOLD_CYCLES);
		if (mismatch_count == 0 && expected_poses.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
